// ----- rtl/fpdx_pkg.sv -----
package fpdx_pkg;

  // Result status codes.
  localparam logic [1:0] ST_GOOD     = 2'd0;
  localparam logic [1:0] ST_BAD_SUM  = 2'd1;
  localparam logic [1:0] ST_TOO_LONG = 2'd2;

  // Input item kinds.
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic [15:0] TIMEOUT_RESET = 16'd40;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] frame_command;
    logic [7:0] payload_length;
    logic [7:0] payload_byte;
    logic [7:0] byte_index;
    logic       byte_valid;
    logic       last;
  } res_t;

  typedef struct packed {
    logic       en;
    logic [7:0] addr;
    logic [7:0] data;
  } mem_wr_t;

  typedef struct packed {
    logic       en;
    logic [7:0] addr;
  } mem_rd_t;

endpackage

// ----- rtl/fpdx_store.sv -----
module fpdx_store #(
  parameter int unsigned DEPTH = 64
) (
  input  logic              clk_i,
  input  fpdx_pkg::mem_wr_t wr_i,
  input  fpdx_pkg::mem_rd_t rd_i,
  output logic [7:0]        rd_data_o
);
  import fpdx_pkg::*;

  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr[AddrW-1:0]] <= wr_i.data;
    end
  end

  // The read data register holds its value while no read is issued.
  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rd_data_q <= mem[rd_i.addr[AddrW-1:0]];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- rtl/fpdx_ctrl.sv -----
module fpdx_ctrl #(
  parameter int unsigned MAX_PAYLOAD = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              byte_take_i,
  input  logic              tick_take_i,
  input  logic [7:0]        data_byte_i,
  input  logic [15:0]       timeout_i,
  input  logic              out_free_i,
  input  logic [7:0]        rd_data_i,
  output logic              busy_o,
  output logic              res_valid_o,
  output fpdx_pkg::res_t    res_o,
  output fpdx_pkg::mem_wr_t mem_wr_o,
  output fpdx_pkg::mem_rd_t mem_rd_o
);
  import fpdx_pkg::*;

  localparam logic [7:0] MaxLen = 8'(MAX_PAYLOAD);

  localparam logic [3:0] PH_U       = 4'd0;
  localparam logic [3:0] PH_N       = 4'd1;
  localparam logic [3:0] PH_E       = 4'd2;
  localparam logic [3:0] PH_R       = 4'd3;
  localparam logic [3:0] PH_LEN     = 4'd4;
  localparam logic [3:0] PH_TOKEN   = 4'd5;
  localparam logic [3:0] PH_CMD     = 4'd6;
  localparam logic [3:0] PH_PAYLOAD = 4'd7;
  localparam logic [3:0] PH_CHECK   = 4'd8;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_WR   = 2'd2;

  localparam logic [7:0] CH_U        = 8'h55;
  localparam logic [7:0] CH_N        = 8'h4E;
  localparam logic [7:0] CH_E        = 8'h45;
  localparam logic [7:0] CH_R        = 8'h52;
  localparam logic [7:0] FRAME_TOKEN = 8'h3A;
  localparam logic [7:0] MIN_LEN     = 8'd2;

  logic [3:0]  phase_q, phase_d, cur_phase;
  logic [7:0]  count_q, count_d;
  logic [7:0]  pos_q, pos_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [7:0]  xor_q, xor_d;
  logic [15:0] elapsed_q, elapsed_d;
  logic [1:0]  strm_q, strm_d;
  logic [7:0]  idx_q, idx_d;
  logic [7:0]  slen_q, slen_d;
  logic [7:0]  scmd_q, scmd_d;
  logic        timed_out;
  logic        last_byte;

  assign timed_out = (phase_q != PH_U) && (elapsed_q > timeout_i);
  assign cur_phase = timed_out ? PH_U : phase_q;
  assign last_byte = ((idx_q + 8'd1) == slen_q);

  always_comb begin
    phase_d     = phase_q;
    count_d     = count_q;
    pos_d       = pos_q;
    cmd_d       = cmd_q;
    xor_d       = xor_q;
    elapsed_d   = elapsed_q;
    strm_d      = strm_q;
    idx_d       = idx_q;
    slen_d      = slen_q;
    scmd_d      = scmd_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    mem_wr_o    = '0;
    mem_rd_o    = '0;

    if (tick_take_i) begin
      if (elapsed_q != 16'hFFFF) begin
        elapsed_d = elapsed_q + 16'd1;
      end
    end else if (byte_take_i) begin
      // A frame that has run out of time is dropped before the byte is parsed.
      if (timed_out) begin
        phase_d = PH_U;
        count_d = '0;
        pos_d   = '0;
        cmd_d   = '0;
        xor_d   = '0;
      end
      unique case (cur_phase)
        PH_U: begin
          if (data_byte_i == CH_U) begin
            xor_d     = data_byte_i;
            elapsed_d = '0;
            phase_d   = PH_N;
          end
        end
        PH_N, PH_E, PH_R: begin
          if ((cur_phase == PH_N && data_byte_i == CH_N) ||
              (cur_phase == PH_E && data_byte_i == CH_E) ||
              (cur_phase == PH_R && data_byte_i == CH_R)) begin
            xor_d   = xor_q ^ data_byte_i;
            phase_d = cur_phase + 4'd1;
          end else begin
            phase_d = PH_U;
            count_d = '0;
            pos_d   = '0;
            cmd_d   = '0;
            xor_d   = '0;
          end
        end
        PH_LEN: begin
          if (data_byte_i >= MIN_LEN) begin
            xor_d   = xor_q ^ data_byte_i;
            count_d = data_byte_i - MIN_LEN;
            pos_d   = '0;
            phase_d = PH_TOKEN;
          end else begin
            phase_d = PH_U;
            count_d = '0;
            pos_d   = '0;
            cmd_d   = '0;
            xor_d   = '0;
          end
        end
        PH_TOKEN: begin
          if (data_byte_i == FRAME_TOKEN) begin
            xor_d   = xor_q ^ data_byte_i;
            phase_d = PH_CMD;
          end else begin
            phase_d = PH_U;
            count_d = '0;
            pos_d   = '0;
            cmd_d   = '0;
            xor_d   = '0;
          end
        end
        PH_CMD: begin
          cmd_d   = data_byte_i;
          xor_d   = xor_q ^ data_byte_i;
          pos_d   = '0;
          phase_d = (count_q != 8'd0) ? PH_PAYLOAD : PH_CHECK;
        end
        PH_PAYLOAD: begin
          // Bytes past the store's depth still count toward the checksum.
          mem_wr_o.en   = (pos_q < MaxLen);
          mem_wr_o.addr = pos_q;
          mem_wr_o.data = data_byte_i;
          xor_d         = xor_q ^ data_byte_i;
          pos_d         = pos_q + 8'd1;
          if ((pos_q + 8'd1) >= count_q) begin
            phase_d = PH_CHECK;
          end
        end
        PH_CHECK: begin
          res_o.frame_command  = cmd_q;
          res_o.payload_length = count_q;
          res_o.last           = 1'b1;
          priority if (count_q > MaxLen) begin
            res_o.status = ST_TOO_LONG;
            res_valid_o  = 1'b1;
          end else if (xor_q != data_byte_i) begin
            res_o.status = ST_BAD_SUM;
            res_valid_o  = 1'b1;
          end else if (count_q == 8'd0) begin
            res_o.status = ST_GOOD;
            res_valid_o  = 1'b1;
          end else begin
            strm_d = S_RD;
            idx_d  = '0;
            slen_d = count_q;
            scmd_d = cmd_q;
          end
          phase_d = PH_U;
          count_d = '0;
          pos_d   = '0;
          cmd_d   = '0;
          xor_d   = '0;
        end
        default: begin
          phase_d = PH_U;
          count_d = '0;
          pos_d   = '0;
          cmd_d   = '0;
          xor_d   = '0;
        end
      endcase
    end

    // Payload run: read one entry, then hand it to the output register.
    unique case (strm_q)
      S_IDLE: begin
      end
      S_RD: begin
        mem_rd_o.en   = 1'b1;
        mem_rd_o.addr = idx_q;
        strm_d        = S_WR;
      end
      S_WR: begin
        if (out_free_i) begin
          res_valid_o          = 1'b1;
          res_o.status         = ST_GOOD;
          res_o.frame_command  = scmd_q;
          res_o.payload_length = slen_q;
          res_o.payload_byte   = rd_data_i;
          res_o.byte_index     = idx_q;
          res_o.byte_valid     = 1'b1;
          res_o.last           = last_byte;
          if (last_byte) begin
            strm_d = S_IDLE;
          end else begin
            idx_d  = idx_q + 8'd1;
            strm_d = S_RD;
          end
        end
      end
      default: begin
        strm_d = S_IDLE;
      end
    endcase
  end

  assign busy_o = (strm_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_U;
      count_q   <= '0;
      pos_q     <= '0;
      cmd_q     <= '0;
      xor_q     <= '0;
      elapsed_q <= '0;
      strm_q    <= S_IDLE;
      idx_q     <= '0;
    end else begin
      phase_q   <= phase_d;
      count_q   <= count_d;
      pos_q     <= pos_d;
      cmd_q     <= cmd_d;
      xor_q     <= xor_d;
      elapsed_q <= elapsed_d;
      strm_q    <= strm_d;
      idx_q     <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slen_q <= slen_d;
    scmd_q <= scmd_d;
  end

endmodule

// ----- rtl/framed_packet_decoder_xor_core.sv -----
// Frame decoder for a byte stream with an XOR checksum.
// Input channel (in_valid_i / in_stall_o): each item is a received byte
// (command_i = 0, data_byte_i) or one time tick (command_i = 1).
// Output channel (out_valid_o / out_stall_i): one item per payload byte of a
// good frame, or a single item for an empty payload, a bad checksum or an
// over-long payload. last_o marks the final item of a frame.
// Configuration channel (cfg_valid_i / cfg_ready_o): writes timeout_ticks;
// it is always ready.
// Each input item is handled as it is taken. A single result is written to
// the output register as the closing byte is taken. A good frame with N
// stored bytes streams them from the payload memory, each item by a read
// state, the memory read register and a load into the output register;
// input is stalled (busy) from the closing byte until the last item loads.
// The input is also stalled while a finished item waits and the receiver
// stalls; items are never dropped or repeated.
// Reset clears the parser, the tick counter and the output valid, and loads
// timeout_ticks with 40. The payload memory needs no clearing pass.
module framed_packet_decoder_xor_core #(
  parameter int unsigned MAX_PAYLOAD = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        command_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [7:0]  frame_command_o,
  output logic [7:0]  payload_length_o,
  output logic [7:0]  payload_byte_o,
  output logic [7:0]  byte_index_o,
  output logic        byte_valid_o,
  output logic        last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_timeout_ticks_i
);
  import fpdx_pkg::*;

  logic [15:0] timeout_q;
  logic        out_valid_q;
  res_t        out_q;
  logic        out_free;
  logic        busy;
  logic        in_take;
  logic        res_valid;
  res_t        res;
  mem_wr_t     mem_wr;
  mem_rd_t     mem_rd;
  logic [7:0]  rd_data;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = busy || !out_free;
  assign in_take     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  fpdx_ctrl #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_take_i (in_take && (command_i == CMD_BYTE)),
    .tick_take_i (in_take && (command_i == CMD_TICK)),
    .data_byte_i (data_byte_i),
    .timeout_i   (timeout_q),
    .out_free_i  (out_free),
    .rd_data_i   (rd_data),
    .busy_o      (busy),
    .res_valid_o (res_valid),
    .res_o       (res),
    .mem_wr_o    (mem_wr),
    .mem_rd_o    (mem_rd)
  );

  fpdx_store #(
    .DEPTH(MAX_PAYLOAD)
  ) u_store (
    .clk_i     (clk_i),
    .wr_i      (mem_wr),
    .rd_i      (mem_rd),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q   <= TIMEOUT_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        timeout_q <= cfg_timeout_ticks_i;
      end
      if (res_valid) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_q.status;
  assign frame_command_o  = out_q.frame_command;
  assign payload_length_o = out_q.payload_length;
  assign payload_byte_o   = out_q.payload_byte;
  assign byte_index_o     = out_q.byte_index;
  assign byte_valid_o     = out_q.byte_valid;
  assign last_o           = out_q.last;

  a_single_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !byte_valid_o |-> last_o)
    else $error("result without payload data is not marked last");

  a_index_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && byte_valid_o |-> byte_index_o < payload_length_o)
    else $error("payload index beyond announced length");

  a_error_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_GOOD |-> !byte_valid_o)
    else $error("error result carries payload data");

  a_run_stalls_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && byte_valid_o && !last_o |-> in_stall_o)
    else $error("input taken in the middle of a payload run");

endmodule
